/* sv/nfa_pkg.sv */
// Shared types, sizes and codes for the NFA word acceptor.
package nfa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 256;
  localparam int STATE_W     = 4;
  localparam int SYM_W       = 8;
  localparam int SYM_AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef logic [NUM_STATES-1:0] set_t;
  typedef logic [STATE_W-1:0]    state_idx_t;
  typedef logic [SYM_AW-1:0]     sym_addr_t;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_SYMBOL = 2'd2;
  localparam logic [1:0] REQ_EOW    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'b1;

  // write request broadcast to every cell
  typedef struct packed {
    logic       en;
    logic       sweep;
    sym_addr_t  addr;
    state_idx_t src;
    state_idx_t dst;
  } ram_wr_t;

  // active-set update broadcast to every cell
  typedef struct packed {
    logic step;
    logic drop;
    logic started;
  } act_ctl_t;

endpackage

/* sv/nfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/nfa_cell.sv */
// One source-state cell: its transition column, its active bit and one OR stage.
module nfa_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  nfa_pkg::state_idx_t cell_idx,
  input  nfa_pkg::ram_wr_t   wr,
  input  logic               rd_en,
  input  nfa_pkg::sym_addr_t rd_addr,
  input  nfa_pkg::act_ctl_t  ctl,
  input  logic               start_bit,
  input  logic               nxt_bit,
  input  nfa_pkg::set_t      acc_in,
  output nfa_pkg::set_t      acc_out,
  output logic               base_bit
);
  import nfa_pkg::*;

  logic act_r;
  logic act_nxt;
  set_t row;

  for (genvar d = 0; d < NUM_STATES; d++) begin : g_dst
    logic bit_we;
    assign bit_we = wr.en &&
                    (wr.sweep || (wr.src == cell_idx && wr.dst == STATE_W'(d)));
    nfa_ram #(
      .WIDTH(1),
      .DEPTH(NUM_SYMBOLS)
    ) u_ram (
      .clk   (clk),
      .we    (bit_we),
      .waddr (wr.addr),
      .wdata (!wr.sweep),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (row[d])
    );
  end

  assign base_bit = ctl.started ? act_r : start_bit;
  assign acc_out  = acc_in | (row & {NUM_STATES{base_bit}});

  always_comb begin
    act_nxt = act_r;
    if (ctl.step) begin
      act_nxt = nxt_bit;
    end else if (ctl.drop) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

/* sv/nfa_word_acceptor.sv */
// Top level of the NFA word acceptor: control, config registers, cell chain, output register.
//
// Symbol, add-edge and end-of-word transactions are each taken at one per clock, back to
// back, except in a sweep or while an end-of-word waits on an unread result; the transition
// column of every state cell is read in the cycle of acceptance and the next active set is
// formed the cycle after by an OR chain through the cells. An end-of-word result passes via
// the evaluation stage register into the output register; a new transaction is accepted while
// a result waits unless an end-of-word waits too. A clear starts a sweep of all NUM_SYMBOLS
// (256) rows that zeroes all cell memories, one row per cycle, during which in_ready is low;
// the same sweep runs straight after reset. Configuration writes are taken at any time.
module nfa_word_acceptor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [nfa_pkg::STATE_W-1:0]       in_from_state,
  input  logic [nfa_pkg::STATE_W-1:0]       in_to_state,
  input  logic [nfa_pkg::SYM_W-1:0]         in_symbol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accepted,
  output nfa_pkg::set_t                     out_final_active,
  input  logic                              cfg_we,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import nfa_pkg::*;

  state_idx_t start_idx_r;
  set_t       final_mask_r;

  logic       sweep_r, sweep_nxt;
  sym_addr_t  sweep_cnt_r, sweep_cnt_nxt;

  logic       s1_v_r, s1_v_nxt;
  logic       s1_eow_r;
  logic       s1_sym_ok_r;

  logic       started_r, started_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_accepted_r;
  set_t       out_final_active_r;

  logic       in_fire;
  logic       edge_ok;
  logic       stall;
  logic       s1_fire;
  ram_wr_t    wr;
  act_ctl_t   ctl;
  set_t       start_set;
  set_t       next_set;
  set_t       base_set;
  set_t       acc [NUM_STATES+1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_idx_r  <= '0;
      final_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_STATE: start_idx_r  <= cfg_wdata[STATE_W-1:0];
        CFG_FINAL_MASK:  final_mask_r <= cfg_wdata[NUM_STATES-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_STATES; s++) begin
      start_set[s] = (start_idx_r == STATE_W'(s));
    end
  end

  assign stall    = s1_v_r && s1_eow_r && out_valid_r && !out_ready;
  assign in_ready = !sweep_r && !stall;
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_v_r && !stall;

  assign edge_ok = (int'(in_from_state) < NUM_STATES) &&
                   (int'(in_to_state) < NUM_STATES) &&
                   (int'(in_symbol) < NUM_SYMBOLS);

  // memory write: zeroing sweep or single edge set
  always_comb begin
    wr.en    = sweep_r || (in_fire && in_req_type == REQ_ADD && edge_ok);
    wr.sweep = sweep_r;
    wr.addr  = sweep_r ? sweep_cnt_r : in_symbol[SYM_AW-1:0];
    wr.src   = in_from_state;
    wr.dst   = in_to_state;
  end

  always_comb begin
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      if (sweep_cnt_r == SYM_AW'(NUM_SYMBOLS - 1)) begin
        sweep_nxt     = 1'b0;
        sweep_cnt_nxt = '0;
      end
    end else if (in_fire && in_req_type == REQ_CLEAR) begin
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else begin
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  // evaluation stage
  always_comb begin
    s1_v_nxt = stall ? s1_v_r : 1'b0;
    if (in_fire && (in_req_type == REQ_SYMBOL || in_req_type == REQ_EOW)) begin
      s1_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_eow_r    <= (in_req_type == REQ_EOW);
      s1_sym_ok_r <= (int'(in_symbol) < NUM_SYMBOLS);
    end
  end

  always_comb begin
    ctl.step    = s1_fire && !s1_eow_r;
    ctl.drop    = s1_fire && s1_eow_r;
    ctl.started = started_r;
  end

  always_comb begin
    started_nxt = started_r;
    if (ctl.step) begin
      started_nxt = 1'b1;
    end else if (ctl.drop) begin
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

  // cell chain
  assign acc[0] = '0;

  for (genvar s = 0; s < NUM_STATES; s++) begin : g_cell
    nfa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (STATE_W'(s)),
      .wr        (wr),
      .rd_en     (in_fire),
      .rd_addr   (in_symbol[SYM_AW-1:0]),
      .ctl       (ctl),
      .start_bit (start_set[s]),
      .nxt_bit   (next_set[s]),
      .acc_in    (acc[s]),
      .acc_out   (acc[s+1]),
      .base_bit  (base_set[s])
    );
  end

  assign next_set = acc[NUM_STATES] & {NUM_STATES{s1_sym_ok_r}};

  // output register
  assign out_valid_nxt = ctl.drop || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drop) begin
      out_accepted_r     <= |(base_set & final_mask_r);
      out_final_active_r <= base_set;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_final_active = out_final_active_r;

endmodule

/* sv/nfa_chk.sv */
// Port-level checker for the NFA word acceptor, bound to the top level.
module nfa_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     in_req_type,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_accepted,
  input nfa_pkg::set_t                  out_final_active
);
  import nfa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction completed");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_accepted) && $stable(out_final_active))
    else $error("result payload changed while stalled");

  a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_final_active != '0)
    else $error("word accepted with empty active set");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_CLEAR |=> !in_ready)
    else $error("transaction taken during clearing sweep");

  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("transaction taken before post-reset sweep");

endmodule

bind nfa_word_acceptor nfa_chk u_nfa_chk (.*);
